// ===== rtl/ordered_list_engine_assert.svh =====
// assertion macros for the ordered list engine
`ifndef ORDERED_LIST_ENGINE_ASSERT_SVH
`define ORDERED_LIST_ENGINE_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define OLE_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ordered list engine check failed");

// next-cycle implication
`define OLE_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ordered list engine check failed");

`else

`define OLE_ASSERT_NOW(lbl, clk, rst, ante, cons)
`define OLE_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

// ===== rtl/ole_pkg.sv =====
`default_nettype none

package ole_pkg;

   localparam int MODE_W = 3;
   localparam int VALUE_W = 32;
   localparam int POS_W = 7;
   localparam int STATUS_W = 2;
   localparam int LEN_W = 7;

   // flags examined per search step at the bottom of the chain
   localparam int SCAN = 8;
   localparam int SCAN_W = 3;

   localparam logic [LEN_W-1:0] NONE_IDX = '1;

   typedef enum logic [MODE_W-1:0] {
      MODE_ADD_FRONT  = 3'd0,
      MODE_ADD_BACK   = 3'd1,
      MODE_TAKE_FRONT = 3'd2,
      MODE_TAKE_BACK  = 3'd3,
      MODE_INSERT     = 3'd4,
      MODE_SEARCH     = 3'd5
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_DONE  = 2'd0,
      STAT_EMPTY = 2'd1,
      STAT_FULL  = 2'd2,
      STAT_RANGE = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_REMOVE,
      CELL_MATCH,
      CELL_SHIFT
   } cell_op_type;

   typedef enum logic {
      ST_IDLE,
      ST_SCAN
   } state_type;

endpackage

`default_nettype wire

// ===== rtl/ole_if.sv =====
`default_nettype none

interface ole_req_if;
   logic                                valid;
   logic                                ready;
   logic [ole_pkg::MODE_W-1:0]          mode;
   logic signed [ole_pkg::VALUE_W-1:0]  value;
   logic [ole_pkg::POS_W-1:0]           position;

   modport source (output valid, output mode, output value, output position, input ready);
   modport sink (input valid, input mode, input value, input position, output ready);
endinterface

interface ole_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [ole_pkg::STATUS_W-1:0]        status;
   logic signed [ole_pkg::LEN_W-1:0]    found_index;
   logic [ole_pkg::LEN_W-1:0]           length;

   modport source (output valid, output status, output found_index, output length, input ready);
   modport sink (input valid, input status, input found_index, input length, output ready);
endinterface

`default_nettype wire

// ===== rtl/ordered_list_engine.sv =====
// ordered list engine: a bounded list of signed words held in a row of cells
//
// req_ch carries one request item (mode, value, position) and rsp_ch gives one
// result item (status, found_index, length) for every request, in order.
// for push, pop and insert the cells shift their words in parallel and the
// result is registered, so it appears the cycle after the request is taken.
// search loads a match flag into every cell in its accept cycle, then the
// flags slide towards cell 0 eight positions per cycle while an eight-way
// priority encoder looks at the bottom of the chain; the next request waits
// until the search is answered.
// reset is synchronous: it empties the list and clears the result valid flag;
// cell contents are not cleared, only words below the length are ever seen.
// a result waits in its register while rsp_ch is stalled; a new request is
// taken only when that register is free or being emptied in the same cycle.
`default_nettype none

`include "ordered_list_engine_assert.svh"

module ordered_list_engine #(
   parameter int CAPACITY = 64,
   parameter int DATA_WIDTH = 32
) (
   input  wire logic   clock,
   input  wire logic   reset,
   ole_req_if.sink     req_ch,
   ole_rsp_if.source   rsp_ch
);

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int LW = ole_pkg::LEN_W;
   localparam int PW = (CNT_W > ole_pkg::POS_W) ? CNT_W : ole_pkg::POS_W;
   localparam int SW = CNT_W + ole_pkg::SCAN_W + 1;
   localparam int SCW = ole_pkg::SCAN_W;
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(CAPACITY);
   localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

   // control state
   ole_pkg::state_type      state_ff, state_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic [CNT_W-1:0]        base_ff, base_in;
   logic                    rsp_valid_ff, rsp_valid_in;

   // result register
   logic [ole_pkg::STATUS_W-1:0] status_ff, status_in;
   logic [LW-1:0]                found_ff, found_in;
   logic [LW-1:0]                length_ff, length_in;

   // chain control
   ole_pkg::cell_op_type    op;
   logic [CNT_W-1:0]        sel;
   logic [DATA_WIDTH-1:0]   word;
   logic [ole_pkg::SCAN-1:0] low_flags;

   logic                    req_ready;
   logic                    accept;
   logic                    is_full;
   logic                    is_empty;
   logic                    any_low;
   logic [SCW-1:0]          enc;
   logic [SW-1:0]           next_base;

   // value is sign-extended or cut to the stored word width
   assign word = DATA_WIDTH'(req_ch.value);

   assign req_ready = (state_ff == ole_pkg::ST_IDLE) && (!rsp_valid_ff || rsp_ch.ready);
   assign accept = req_ch.valid && req_ready;
   assign is_full = (cnt_ff == FULL_CNT);
   assign is_empty = (cnt_ff == '0);
   assign any_low = |low_flags;
   assign next_base = SW'(base_ff) + SW'(ole_pkg::SCAN);

   // lowest set flag among the bottom cells
   always_comb begin
      enc = '0;
      for (int k = ole_pkg::SCAN - 1; k >= 0; k--) begin
         if (low_flags[k]) begin
            enc = SCW'(k);
         end
      end
   end

   ole_chain #(
      .CAPACITY   (CAPACITY),
      .DATA_WIDTH (DATA_WIDTH),
      .CNT_W      (CNT_W)
   ) u_chain (
      .clock     (clock),
      .reset     (reset),
      .op        (op),
      .sel       (sel),
      .count     (cnt_ff),
      .word      (word),
      .low_flags (low_flags)
   );

   // next state, chain command and result
   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      base_in = base_ff;
      op = ole_pkg::CELL_HOLD;
      sel = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      status_in = status_ff;
      found_in = found_ff;
      length_in = length_ff;

      case (state_ff)
         ole_pkg::ST_IDLE: begin
            if (accept) begin
               // most requests answer right away
               rsp_valid_in = 1'b1;
               status_in = ole_pkg::STAT_DONE;
               found_in = ole_pkg::NONE_IDX;
               case (ole_pkg::mode_type'(req_ch.mode))
                  ole_pkg::MODE_ADD_FRONT, ole_pkg::MODE_ADD_BACK: begin
                     if (is_full) begin
                        status_in = ole_pkg::STAT_FULL;
                     end else begin
                        op = ole_pkg::CELL_INSERT;
                        sel = (ole_pkg::mode_type'(req_ch.mode) == ole_pkg::MODE_ADD_FRONT)
                              ? '0 : cnt_ff;
                        cnt_in = cnt_ff + CNT_ONE;
                     end
                  end
                  ole_pkg::MODE_TAKE_FRONT, ole_pkg::MODE_TAKE_BACK: begin
                     if (is_empty) begin
                        status_in = ole_pkg::STAT_EMPTY;
                     end else begin
                        // popping the back only shortens the list
                        if (ole_pkg::mode_type'(req_ch.mode) == ole_pkg::MODE_TAKE_FRONT) begin
                           op = ole_pkg::CELL_REMOVE;
                        end
                        cnt_in = cnt_ff - CNT_ONE;
                     end
                  end
                  ole_pkg::MODE_INSERT: begin
                     if (is_full) begin
                        status_in = ole_pkg::STAT_FULL;
                     end else if (PW'(req_ch.position) > PW'(cnt_ff)) begin
                        status_in = ole_pkg::STAT_RANGE;
                     end else begin
                        op = ole_pkg::CELL_INSERT;
                        sel = CNT_W'(req_ch.position);
                        cnt_in = cnt_ff + CNT_ONE;
                     end
                  end
                  ole_pkg::MODE_SEARCH: begin
                     if (is_empty) begin
                        status_in = ole_pkg::STAT_EMPTY;
                     end else begin
                        // compare in every cell, answer after the scan
                        op = ole_pkg::CELL_MATCH;
                        base_in = '0;
                        rsp_valid_in = 1'b0;
                        state_in = ole_pkg::ST_SCAN;
                     end
                  end
                  default: begin
                  end
               endcase
               length_in = LW'(cnt_in);
            end
         end
         ole_pkg::ST_SCAN: begin
            if (any_low) begin
               rsp_valid_in = 1'b1;
               status_in = ole_pkg::STAT_DONE;
               found_in = LW'(SW'(base_ff) + SW'(enc));
               length_in = LW'(cnt_ff);
               state_in = ole_pkg::ST_IDLE;
            end else if (next_base >= SW'(cnt_ff)) begin
               // every valid entry has passed the bottom without a hit
               rsp_valid_in = 1'b1;
               status_in = ole_pkg::STAT_DONE;
               found_in = ole_pkg::NONE_IDX;
               length_in = LW'(cnt_ff);
               state_in = ole_pkg::ST_IDLE;
            end else begin
               op = ole_pkg::CELL_SHIFT;
               base_in = CNT_W'(next_base);
            end
         end
         default: begin
            state_in = ole_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ole_pkg::ST_IDLE;
         cnt_ff <= '0;
         base_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         base_ff <= base_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload, no reset needed
   always_ff @(posedge clock) begin
      status_ff <= status_in;
      found_ff <= found_in;
      length_ff <= length_in;
   end

   assign req_ch.ready = req_ready;
   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.status = status_ff;
   assign rsp_ch.found_index = found_ff;
   assign rsp_ch.length = length_ff;

   // the length never grows past the capacity
   `OLE_ASSERT_NOW(a_cnt_bound, clock, reset, 1'b1, cnt_ff <= FULL_CNT)
   // a waiting result always reports the current length
   `OLE_ASSERT_NOW(a_len_match, clock, reset, rsp_valid_ff, length_ff == LW'(cnt_ff))
   // while scanning, the result register is free
   `OLE_ASSERT_NOW(a_scan_free, clock, reset, state_ff == ole_pkg::ST_SCAN, !rsp_valid_ff)
   // a request that is not a search is answered in the next cycle
   `OLE_ASSERT_NEXT(a_quick_rsp, clock, reset,
      accept && (req_ch.mode != ole_pkg::MODE_SEARCH), rsp_valid_ff)

endmodule

`default_nettype wire

// ===== rtl/ole_cell.sv =====
`default_nettype none

module ole_cell #(
   parameter int INDEX = 0,
   parameter int DATA_WIDTH = 32,
   parameter int CNT_W = 7
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire ole_pkg::cell_op_type    op,
   input  wire logic [CNT_W-1:0]        sel,
   input  wire logic [CNT_W-1:0]        count,
   input  wire logic [DATA_WIDTH-1:0]   word,
   input  wire logic [DATA_WIDTH-1:0]   left_data,
   input  wire logic [DATA_WIDTH-1:0]   right_data,
   input  wire logic                    right_flag,
   output      logic [DATA_WIDTH-1:0]   data,
   output      logic                    flag
);

   localparam logic [CNT_W-1:0] IDX = CNT_W'(INDEX);

   logic [DATA_WIDTH-1:0] data_ff, data_in;
   logic                  flag_ff, flag_in;

   always_comb begin
      data_in = data_ff;
      flag_in = flag_ff;
      case (op)
         ole_pkg::CELL_INSERT: begin
            if (IDX == sel) begin
               data_in = word;
            end else if (IDX > sel) begin
               data_in = left_data;
            end
         end
         ole_pkg::CELL_REMOVE: begin
            if (IDX >= sel) begin
               data_in = right_data;
            end
         end
         ole_pkg::CELL_MATCH: begin
            flag_in = (IDX < count) && (data_ff == word);
         end
         ole_pkg::CELL_SHIFT: begin
            flag_in = right_flag;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flag_ff <= 1'b0;
      end else begin
         flag_ff <= flag_in;
      end
   end

   assign data = data_ff;
   assign flag = flag_ff;

endmodule

`default_nettype wire

// ===== rtl/ole_chain.sv =====
`default_nettype none

module ole_chain #(
   parameter int CAPACITY = 64,
   parameter int DATA_WIDTH = 32,
   parameter int CNT_W = 7
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire ole_pkg::cell_op_type       op,
   input  wire logic [CNT_W-1:0]           sel,
   input  wire logic [CNT_W-1:0]           count,
   input  wire logic [DATA_WIDTH-1:0]      word,
   output      logic [ole_pkg::SCAN-1:0]   low_flags
);

   logic [DATA_WIDTH-1:0] data [CAPACITY];
   logic [CAPACITY-1:0]   flags;

   genvar g;
   generate
      for (g = 0; g < CAPACITY; g++) begin : g_cell
         logic [DATA_WIDTH-1:0] left_d, right_d;
         logic                  right_f;

         if (g == 0) begin : g_first
            assign left_d = '0;
         end else begin : g_mid
            assign left_d = data[g-1];
         end

         if (g == CAPACITY - 1) begin : g_last
            assign right_d = '0;
         end else begin : g_inner
            assign right_d = data[g+1];
         end

         // search flags move down by one scan step per cycle while the chain is told to shift
         if (g + ole_pkg::SCAN < CAPACITY) begin : g_flag_in
            assign right_f = flags[g+ole_pkg::SCAN];
         end else begin : g_flag_end
            assign right_f = 1'b0;
         end

         ole_cell #(
            .INDEX      (g),
            .DATA_WIDTH (DATA_WIDTH),
            .CNT_W      (CNT_W)
         ) u_cell (
            .clock      (clock),
            .reset      (reset),
            .op         (op),
            .sel        (sel),
            .count      (count),
            .word       (word),
            .left_data  (left_d),
            .right_data (right_d),
            .right_flag (right_f),
            .data       (data[g]),
            .flag       (flags[g])
         );
      end

      for (g = 0; g < ole_pkg::SCAN; g++) begin : g_low
         if (g < CAPACITY) begin : g_real
            assign low_flags[g] = flags[g];
         end else begin : g_pad
            assign low_flags[g] = 1'b0;
         end
      end
   endgenerate

endmodule

`default_nettype wire

// ===== tb/sv/ole_result_check.sv =====
// watches both channels of the ordered list engine, keeps a shadow copy of
// the list and compares every result item with the answer it predicts
module ole_result_check #(
   parameter int CAPACITY = 64
) (
   input  wire logic clock,
   input  wire logic reset,
   ole_req_if        req_mon,
   ole_rsp_if        rsp_mon,
   output int        mismatches,
   output int        outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      ole_pkg::status_type                     status;
      logic signed [ole_pkg::LEN_W-1:0]        found_index;
      logic [ole_pkg::LEN_W-1:0]               length;
   } list_answer_type;

   logic signed [ole_pkg::VALUE_W-1:0] list_words[$];
   list_answer_type                    expected_answers[$];

   // applies one request to the shadow list and returns its answer
   function automatic list_answer_type apply_request(
         input logic [ole_pkg::MODE_W-1:0] mode,
         input logic signed [ole_pkg::VALUE_W-1:0] value,
         input logic [ole_pkg::POS_W-1:0] position);
      list_answer_type ans;
      int              hit;
      ans.status      = ole_pkg::STAT_DONE;
      ans.found_index = ole_pkg::NONE_IDX;
      hit             = -1;
      case (mode)
         ole_pkg::MODE_ADD_FRONT, ole_pkg::MODE_ADD_BACK: begin
            if (list_words.size() >= CAPACITY)
               ans.status = ole_pkg::STAT_FULL;
            else if (mode == ole_pkg::MODE_ADD_FRONT)
               list_words.insert(0, value);
            else
               list_words.insert(list_words.size(), value);
         end
         ole_pkg::MODE_TAKE_FRONT, ole_pkg::MODE_TAKE_BACK: begin
            if (list_words.size() == 0)
               ans.status = ole_pkg::STAT_EMPTY;
            else if (mode == ole_pkg::MODE_TAKE_FRONT)
               list_words.delete(0);
            else
               list_words.delete(list_words.size() - 1);
         end
         ole_pkg::MODE_INSERT: begin
            // fullness wins over a bad position
            if (list_words.size() >= CAPACITY)
               ans.status = ole_pkg::STAT_FULL;
            else if (int'(position) > list_words.size())
               ans.status = ole_pkg::STAT_RANGE;
            else
               list_words.insert(int'(position), value);
         end
         ole_pkg::MODE_SEARCH: begin
            if (list_words.size() == 0) begin
               ans.status = ole_pkg::STAT_EMPTY;
            end else begin
               for (int i = 0; i < list_words.size(); i++)
                  if (hit < 0 && list_words[i] == value)
                     hit = i;
               if (hit >= 0)
                  ans.found_index = ole_pkg::LEN_W'(hit);
            end
         end
         default: ;
      endcase
      ans.length = ole_pkg::LEN_W'(list_words.size());
      return ans;
   endfunction

   always @(posedge clock) begin : watch
      list_answer_type want;
      if (reset) begin
         list_words.delete();
         expected_answers.delete();
         mismatches = 0;
      end else begin
         // a result can never belong to a request taken at the same edge
         if (rsp_mon.valid === 1'b1 && rsp_mon.ready === 1'b1) begin
            if (expected_answers.size() == 0) begin
               $error("result item with no request waiting: status %0d length %0d",
                      rsp_mon.status, rsp_mon.length);
               mismatches++;
            end else begin
               want = expected_answers[0];
               expected_answers.delete(0);
               if (rsp_mon.status !== want.status) begin
                  $error("status: expected %0d, actual %0d", want.status, rsp_mon.status);
                  mismatches++;
               end
               if (rsp_mon.found_index !== want.found_index) begin
                  $error("found_index: expected %0d, actual %0d",
                         $signed(want.found_index), $signed(rsp_mon.found_index));
                  mismatches++;
               end
               if (rsp_mon.length !== want.length) begin
                  $error("length: expected %0d, actual %0d", want.length, rsp_mon.length);
                  mismatches++;
               end
            end
         end
         if (req_mon.valid === 1'b1 && req_mon.ready === 1'b1)
            expected_answers.insert(expected_answers.size(),
                                    apply_request(req_mon.mode, req_mon.value,
                                                  req_mon.position));
      end
      outstanding = expected_answers.size();
   end

endmodule

// ===== tb/sv/ordered_list_engine_test.sv =====
// top of the ordered list engine bench: clock, reset, request stimulus and
// result back-pressure; all prediction lives in the result check beside it
module ordered_list_engine_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CAPACITY = 64;
   // far beyond the slowest legal run (gaps, stalls and full-length searches)
   localparam int CYCLE_LIMIT = 200000;

   // the two mode codes the block leaves unused
   localparam logic [ole_pkg::MODE_W-1:0] MODE_SPARE_LO = 3'd6;
   localparam logic [ole_pkg::MODE_W-1:0] MODE_SPARE_HI = 3'd7;

   // how a random phase leans: towards growth, balance or shrinkage
   typedef enum int {
      PHASE_FILL,
      PHASE_MIXED,
      PHASE_DRAIN
   } phase_kind_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   mismatches;
   int   outstanding;
   int   cycle_count = 0;
   bit   sender_idle = 1'b1;

   // search and add values are mostly drawn from a small pool so that
   // searches actually hit entries already in the list
   logic signed [ole_pkg::VALUE_W-1:0] value_pool[8];

   ole_req_if req_ch();
   ole_rsp_if rsp_ch();

   ordered_list_engine #(
      .CAPACITY   (CAPACITY),
      .DATA_WIDTH (ole_pkg::VALUE_W)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   ole_result_check #(
      .CAPACITY (CAPACITY)
   ) result_check (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_ch),
      .rsp_mon     (rsp_ch),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // watchdog: a hung handshake ends the run here
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // offers one request item after an optional idle gap and holds it until taken
   task automatic offer_request(input logic [ole_pkg::MODE_W-1:0] mode,
                                input logic signed [ole_pkg::VALUE_W-1:0] value,
                                input logic [ole_pkg::POS_W-1:0] position);
      int gap;
      gap = sender_idle ? $urandom_range(0, 8) : 0;
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid    <= 1'b1;
      req_ch.mode     <= mode;
      req_ch.value    <= value;
      req_ch.position <= position;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
   endtask

   // sender goes quiet until every predicted result item has come back
   task automatic await_results();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      wait (outstanding == 0);
      @(posedge clock);
   endtask

   function automatic logic [ole_pkg::MODE_W-1:0] pick_mode(input phase_kind_type kind);
      int w_add;
      int w_pop;
      int w_search;
      int r;
      case (kind)
         PHASE_FILL:  begin w_add = 88; w_pop = 4;  w_search = 6;  end
         PHASE_MIXED: begin w_add = 45; w_pop = 35; w_search = 16; end
         default:     begin w_add = 12; w_pop = 76; w_search = 10; end
      endcase
      r = $urandom_range(0, 99);
      if (r < w_add) begin
         case ($urandom_range(0, 2))
            0:       return ole_pkg::MODE_ADD_FRONT;
            1:       return ole_pkg::MODE_ADD_BACK;
            default: return ole_pkg::MODE_INSERT;
         endcase
      end
      if (r < w_add + w_pop)
         return $urandom_range(0, 1) ? ole_pkg::MODE_TAKE_BACK : ole_pkg::MODE_TAKE_FRONT;
      if (r < w_add + w_pop + w_search)
         return ole_pkg::MODE_SEARCH;
      return $urandom_range(0, 1) ? MODE_SPARE_HI : MODE_SPARE_LO;
   endfunction

   function automatic logic signed [ole_pkg::VALUE_W-1:0] pick_value();
      if ($urandom_range(0, 9) < 7)
         return value_pool[$urandom_range(0, 7)];
      return $urandom;
   endfunction

   // small positions succeed on short lists, the upper band is always out of range
   function automatic logic [ole_pkg::POS_W-1:0] pick_position();
      int r;
      r = $urandom_range(0, 9);
      if (r < 5)
         return ole_pkg::POS_W'($urandom_range(0, 8));
      if (r < 9)
         return ole_pkg::POS_W'($urandom_range(0, CAPACITY));
      return ole_pkg::POS_W'($urandom_range(CAPACITY + 1, 127));
   endfunction

   // result side: random back-pressure per item, idle-free stretches,
   // and two long hold-offs so the result register fills and req stalls
   initial begin : result_sink
      int stall;
      int taken;
      rsp_ch.ready = 1'b0;
      taken = 0;
      do @(posedge clock); while (reset);
      forever begin
         if (taken == 120 || taken == 330)
            stall = 64;
         else if ((taken / 50) % 3 == 2)
            stall = 0;
         else
            stall = $urandom_range(0, 8);
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1));
         taken++;
      end
   end

   initial begin : stimulus
      phase_kind_type plan[6];
      int             phase_len[6];
      // every input known from time zero
      req_ch.valid    = 1'b0;
      req_ch.mode     = ole_pkg::MODE_ADD_FRONT;
      req_ch.value    = '0;
      req_ch.position = '0;

      plan      = '{PHASE_FILL, PHASE_MIXED, PHASE_FILL, PHASE_DRAIN, PHASE_MIXED, PHASE_DRAIN};
      phase_len = '{80, 60, 60, 90, 60, 80};

      value_pool[0] = 32'sh7FFF_FFFF;
      value_pool[1] = 32'sh8000_0000;
      value_pool[2] = '0;
      value_pool[3] = '1;
      for (int i = 4; i < 8; i++)
         value_pool[i] = $urandom;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: empty list corner cases first
      offer_request(ole_pkg::MODE_TAKE_FRONT, 32'sd0, 7'd0);
      offer_request(ole_pkg::MODE_TAKE_BACK, 32'sd0, 7'd0);
      offer_request(ole_pkg::MODE_SEARCH, 32'sd0, 7'd0);
      // insert past the length of an empty list
      offer_request(ole_pkg::MODE_INSERT, 32'sd9, 7'd1);
      // insert at position zero behaves as add at the front
      offer_request(ole_pkg::MODE_INSERT, 32'sh7FFF_FFFF, 7'd0);
      offer_request(ole_pkg::MODE_ADD_BACK, 32'sh8000_0000, 7'd0);
      offer_request(ole_pkg::MODE_ADD_FRONT, -32'sd1, 7'd127);
      // insert at the length appends
      offer_request(ole_pkg::MODE_INSERT, 32'sd0, 7'd3);
      offer_request(ole_pkg::MODE_INSERT, 32'sd77, 7'd127);
      // search must see the last entry too
      offer_request(ole_pkg::MODE_SEARCH, 32'sd0, 7'd0);
      offer_request(ole_pkg::MODE_SEARCH, 32'sh8000_0000, 7'd0);
      offer_request(ole_pkg::MODE_SEARCH, 32'sd12345, 7'd0);
      offer_request(MODE_SPARE_LO, 32'sd0, 7'd0);
      offer_request(MODE_SPARE_HI, 32'sh7FFF_FFFF, 7'd64);
      offer_request(ole_pkg::MODE_INSERT, 32'sd5, 7'd1);
      offer_request(ole_pkg::MODE_TAKE_FRONT, 32'sd0, 7'd0);
      offer_request(ole_pkg::MODE_TAKE_BACK, 32'sd0, 7'd0);
      offer_request(ole_pkg::MODE_TAKE_BACK, 32'sd0, 7'd0);
      offer_request(ole_pkg::MODE_TAKE_FRONT, 32'sd0, 7'd0);
      // removing the only entry leaves an empty list
      offer_request(ole_pkg::MODE_TAKE_BACK, 32'sd0, 7'd0);
      offer_request(ole_pkg::MODE_SEARCH, -32'sd1, 7'd0);
      offer_request(ole_pkg::MODE_ADD_BACK, 32'sd0, 7'd0);
      await_results();

      // random phases; two of them run with no sender gaps at all
      for (int p = 0; p < 6; p++) begin
         sender_idle = (p != 2 && p != 4);
         for (int n = 0; n < phase_len[p]; n++)
            offer_request(pick_mode(plan[p]), pick_value(), pick_position());
         await_results();
      end

      // drain time for a full-length search
      repeat (20) @(posedge clock);
      if (mismatches == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
